// ----- hdl/mbe_pkg.sv -----
// Shared types, constants and helpers for the Mandelbrot escape-count block.
// No dependencies; imported by every module under hdl/.
`timescale 1ns / 1ps

package mbe_pkg;

   // Field and datapath widths
   localparam int COORD_W   = 12;   // pixel column / row
   localparam int CNT_W     = 24;   // iteration count and limit
   localparam int CSR_W     = 32;   // widest configuration register
   localparam int CSR_IDX_W = 3;    // five registers
   localparam int OPND_W    = 32;   // multiplier operand
   localparam int PROD_W    = 64;   // multiplier product
   localparam int SQ_W      = 63;   // square of an operand below 2^31
   localparam int Q_W       = 40;   // Q12.28 working format
   localparam int SUM_W     = 48;   // pre-saturation sums
   localparam int FRAC_BITS = 28;

   // |z|^2 < 4.0 in Q.28 means x*x + y*y < 2^(28+30)
   localparam int ESC_BIT = FRAC_BITS + 30;

   localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_STEP = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_STEP = 3'd4;

   // Register reset values
   localparam logic [CNT_W-1:0] RST_MAX_ITER = 24'd1000;
   localparam logic [CSR_W-1:0] RST_LEFT     = 32'hE000_0000;  // -2.0
   localparam logic [CSR_W-1:0] RST_COL_STEP = 32'h0004_0000;  // 2^-10
   localparam logic [CSR_W-1:0] RST_LOWER    = 32'hF000_0000;  // -1.0
   localparam logic [CSR_W-1:0] RST_ROW_STEP = 32'h0004_0000;  // 2^-10

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CRE,    // column * column_step
      ST_CIM,    // row * row_step, load c_re
      ST_INIT,   // load c_im, clear z
      ST_TEST,   // limit and escape check
      ST_XY,     // x * y, form x^2 - y^2
      ST_UPD,    // new z, bump count
      ST_XX,     // x * x, or flag a huge z
      ST_YY,     // y * y
      ST_SUM     // |z|^2 escape compare
   } state_type;

   typedef enum logic [2:0] {
      MUL_COL,
      MUL_ROW,
      MUL_XY,
      MUL_XX,
      MUL_YY
   } mul_sel_type;

   typedef struct packed {
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        load_cre;
      logic        init;
      logic        save_dif;
      logic        upd_z;
      logic        save_xx;
      logic        save_yy;
      logic        set_big;
      logic        emit;
   } ctrl_type;

   typedef struct packed {
      logic go;    // below the limit and not escaped
      logic big;   // |x| or |y| at least 2^31 (Q.28: 8.0)
   } stat_type;

   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
      logic signed [Q_W-1:0] r;
      if (v > SUM_W'(Q_MAX))
         r = Q_MAX;
      else if (v < SUM_W'(Q_MIN))
         r = Q_MIN;
      else
         r = v[Q_W-1:0];
      return r;
   endfunction

endpackage

// ----- hdl/mbe_mul.sv -----
// Shared 32x32 signed multiplier with a registered product.
// Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_mul (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [mbe_pkg::OPND_W-1:0]   a,
   input  logic signed [mbe_pkg::OPND_W-1:0]   b,
   output logic signed [mbe_pkg::PROD_W-1:0]   prod
);
   import mbe_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(a) * PROD_W'(b);

   // hold the product until the next multiply
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ----- hdl/mbe_ctrl.sv -----
// Sequencer for the escape-count loop: steps the shared multiplier.
// Depends on mbe_pkg.
`timescale 1ns / 1ps

module mbe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  mbe_pkg::stat_type  stat,
   output mbe_pkg::ctrl_type  ctrl,
   output logic               busy
);
   import mbe_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_CRE;
         end
         ST_CRE:  state_in = ST_CIM;
         ST_CIM:  state_in = ST_INIT;
         ST_INIT: state_in = ST_TEST;
         ST_TEST: begin
            state_in = stat.go ? ST_XY : ST_IDLE;
         end
         ST_XY:   state_in = ST_UPD;
         ST_UPD:  state_in = ST_XX;
         ST_XX: begin
            state_in = stat.big ? ST_TEST : ST_YY;
         end
         ST_YY:   state_in = ST_SUM;
         ST_SUM:  state_in = ST_TEST;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl = '0;
      ctrl.mul_sel = MUL_XY;
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_CRE: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_COL;
         end
         ST_CIM: begin
            ctrl.mul_en   = 1'b1;
            ctrl.mul_sel  = MUL_ROW;
            ctrl.load_cre = 1'b1;
         end
         ST_INIT: begin
            ctrl.init = 1'b1;
         end
         ST_TEST: begin
            ctrl.emit = !stat.go;
         end
         ST_XY: begin
            ctrl.mul_en   = 1'b1;
            ctrl.mul_sel  = MUL_XY;
            ctrl.save_dif = 1'b1;
         end
         ST_UPD: begin
            ctrl.upd_z = 1'b1;
         end
         ST_XX: begin
            ctrl.mul_en  = !stat.big;
            ctrl.mul_sel = MUL_XX;
            ctrl.set_big = stat.big;
         end
         ST_YY: begin
            ctrl.mul_en  = 1'b1;
            ctrl.mul_sel = MUL_YY;
            ctrl.save_xx = 1'b1;
         end
         ST_SUM: begin
            ctrl.save_yy = 1'b1;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule

// ----- hdl/mandelbrot_escape_count.sv -----
// Top level of the Mandelbrot escape-count block: registers, datapath, result.
// Depends on mbe_pkg, mbe_mul and mbe_ctrl.
// Items are taken one at a time: busy stays high from the accepting edge until the
// sequencer returns to idle, as the single shared multiplier does three products per
// iteration (only x*y when z passes 8.0). Receiver cannot stall.
// Synchronous active-high reset returns to idle and loads the register defaults.
`timescale 1ns / 1ps

module mandelbrot_escape_count (
   input  logic                             clock,
   input  logic                             reset,
   // item in
   input  logic                             start,
   output logic                             busy,
   input  logic [mbe_pkg::COORD_W-1:0]      req_column,
   input  logic [mbe_pkg::COORD_W-1:0]      req_pixel_row,
   // result out, one cycle per item
   output logic                             rsp_strobe,
   output logic [mbe_pkg::COORD_W-1:0]      rsp_out_column,
   output logic [mbe_pkg::COORD_W-1:0]      rsp_out_row,
   output logic [mbe_pkg::CNT_W-1:0]        rsp_iteration_count,
   // configuration writes
   input  logic                             csr_we,
   input  logic [mbe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mbe_pkg::CSR_W-1:0]        csr_wdata
);
   import mbe_pkg::*;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [CNT_W-1:0]        max_ff;
   logic signed [CSR_W-1:0] left_ff;
   logic signed [CSR_W-1:0] cstep_ff;
   logic signed [CSR_W-1:0] lower_ff;
   logic signed [CSR_W-1:0] rstep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= RST_MAX_ITER;
         left_ff  <= RST_LEFT;
         cstep_ff <= RST_COL_STEP;
         lower_ff <= RST_LOWER;
         rstep_ff <= RST_ROW_STEP;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_ITER: max_ff   <= csr_wdata[CNT_W-1:0];
            CSR_LEFT:     left_ff  <= csr_wdata;
            CSR_COL_STEP: cstep_ff <= csr_wdata;
            CSR_LOWER:    lower_ff <= csr_wdata;
            CSR_ROW_STEP: rstep_ff <= csr_wdata;
            default: begin
               // unmapped index: drop the write
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Sequencer and shared multiplier
   // ------------------------------------------------------------------
   ctrl_type ctrl;
   stat_type stat;
   logic     accept;

   mbe_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   assign accept = start && !busy;

   logic [COORD_W-1:0]        col_ff;
   logic [COORD_W-1:0]        row_ff;
   logic signed [Q_W-1:0]     cre_ff;
   logic signed [Q_W-1:0]     cim_ff;
   logic signed [Q_W-1:0]     x_ff;
   logic signed [Q_W-1:0]     y_ff;
   logic [SQ_W-1:0]           xx_ff;   // x*x from the last |z|^2 pass
   logic [SQ_W-1:0]           yy_ff;
   logic signed [PROD_W-1:0]  dif_ff;  // x*x - y*y
   logic                      esc_ff;  // |z|^2 reached 4.0 or z passed 8.0
   logic [CNT_W-1:0]          count_ff;

   logic signed [OPND_W-1:0]  mul_a;
   logic signed [OPND_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]  prod;

   // Operand select: coordinates for c, then the low 32 bits of z. When a
   // square or x*y is taken, |x| and |y| are known to be below 2^31.
   always_comb begin
      case (ctrl.mul_sel)
         MUL_COL: begin
            mul_a = {{(OPND_W-COORD_W){1'b0}}, col_ff};
            mul_b = cstep_ff;
         end
         MUL_ROW: begin
            mul_a = {{(OPND_W-COORD_W){1'b0}}, row_ff};
            mul_b = rstep_ff;
         end
         MUL_XX: begin
            mul_a = x_ff[OPND_W-1:0];
            mul_b = x_ff[OPND_W-1:0];
         end
         MUL_YY: begin
            mul_a = y_ff[OPND_W-1:0];
            mul_b = y_ff[OPND_W-1:0];
         end
         default: begin
            mul_a = x_ff[OPND_W-1:0];
            mul_b = y_ff[OPND_W-1:0];
         end
      endcase
   end

   mbe_mul u_mul (
      .clock (clock),
      .en    (ctrl.mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // ------------------------------------------------------------------
   // Datapath
   // ------------------------------------------------------------------
   logic signed [SUM_W-1:0]  cre_sum;
   logic signed [SUM_W-1:0]  cim_sum;
   logic signed [SUM_W-1:0]  nx_sum;
   logic signed [SUM_W-1:0]  ny_sum;
   logic signed [PROD_W-1:0] dif_shr;
   logic signed [PROD_W-1:0] xy2_shr;
   logic [PROD_W-1:0]        sq_sum;
   logic signed [Q_W-1:0]    cre_in;
   logic signed [Q_W-1:0]    cim_in;
   logic signed [Q_W-1:0]    x_in;
   logic signed [Q_W-1:0]    y_in;
   logic signed [PROD_W-1:0] dif_in;
   logic                     esc_in;
   logic [CNT_W-1:0]         count_in;

   // magnitude of 2^31 (8.0) or more
   function automatic logic is_big(input logic signed [Q_W-1:0] v);
      logic r;
      if (v[Q_W-1])
         r = !(&v[Q_W-2:OPND_W-1]) || (v[OPND_W-2:0] == '0);
      else
         r = |v[Q_W-2:OPND_W-1];
      return r;
   endfunction

   // c = edge + index*step, saturated to Q12.28
   assign cre_sum = {{(SUM_W-CSR_W){left_ff[CSR_W-1]}}, left_ff} + prod[SUM_W-1:0];
   assign cim_sum = {{(SUM_W-CSR_W){lower_ff[CSR_W-1]}}, lower_ff} + prod[SUM_W-1:0];
   assign cre_in  = sat_q(cre_sum);
   assign cim_in  = sat_q(cim_sum);

   // z' = z^2 + c; arithmetic shift floors, 2xy folds into the shift
   assign dif_in  = $signed({1'b0, xx_ff}) - $signed({1'b0, yy_ff});
   assign dif_shr = dif_ff >>> FRAC_BITS;
   assign xy2_shr = prod >>> (FRAC_BITS - 1);
   assign nx_sum  = dif_shr[SUM_W-1:0] + {{(SUM_W-Q_W){cre_ff[Q_W-1]}}, cre_ff};
   assign ny_sum  = xy2_shr[SUM_W-1:0] + {{(SUM_W-Q_W){cim_ff[Q_W-1]}}, cim_ff};
   assign x_in    = sat_q(nx_sum);
   assign y_in    = sat_q(ny_sum);

   // escape once x*x + y*y reaches 4.0 in Q.28 (saturation never hides it)
   assign sq_sum  = {1'b0, xx_ff} + {1'b0, prod[SQ_W-1:0]};
   assign esc_in  = |sq_sum[PROD_W-1:ESC_BIT];

   assign count_in = count_ff + 1'b1;

   assign stat.go  = (count_ff < max_ff) && !esc_ff;
   assign stat.big = is_big(x_ff) || is_big(y_ff);

   // latch the pixel position on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff <= req_column;
         row_ff <= req_pixel_row;
      end
   end

   // c and z payload
   always_ff @(posedge clock) begin
      if (ctrl.load_cre) begin
         cre_ff <= cre_in;
      end
      if (ctrl.init) begin
         cim_ff <= cim_in;
         x_ff   <= '0;
         y_ff   <= '0;
         xx_ff  <= '0;
         yy_ff  <= '0;
      end
      if (ctrl.save_dif) begin
         dif_ff <= dif_in;
      end
      if (ctrl.upd_z) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
      if (ctrl.save_xx) begin
         xx_ff <= prod[SQ_W-1:0];
      end
      if (ctrl.save_yy) begin
         yy_ff <= prod[SQ_W-1:0];
      end
   end

   // loop control: count and escape flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         esc_ff   <= 1'b0;
      end else begin
         if (ctrl.init) begin
            count_ff <= '0;
            esc_ff   <= 1'b0;
         end else begin
            if (ctrl.upd_z) count_ff <= count_in;
            if (ctrl.set_big) esc_ff <= 1'b1;
            if (ctrl.save_yy) esc_ff <= esc_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result register: strobe for one cycle, payload held until next item
   // ------------------------------------------------------------------
   logic                rsp_strobe_ff;
   logic [COORD_W-1:0]  rsp_col_ff;
   logic [COORD_W-1:0]  rsp_row_ff;
   logic [CNT_W-1:0]    rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ctrl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_col_ff   <= col_ff;
         rsp_row_ff   <= row_ff;
         rsp_count_ff <= count_ff;
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_out_column      = rsp_col_ff;
   assign rsp_out_row         = rsp_row_ff;
   assign rsp_iteration_count = rsp_count_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after accepting an item");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while still working");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_iteration_count <= max_ff))
      else $error("iteration count beyond the limit");

   // an iteration only starts with |z| below 2.0, so z fits the multiplier
   a_xy_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.mul_en && ctrl.mul_sel == MUL_XY) |->
         ((x_ff[Q_W-1:FRAC_BITS+1] == '0 || x_ff[Q_W-1:FRAC_BITS+1] == '1) &&
          (y_ff[Q_W-1:FRAC_BITS+1] == '0 || y_ff[Q_W-1:FRAC_BITS+1] == '1)))
      else $error("z out of range at the start of an iteration");

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for mandelbrot_escape_count: directed plan, then randomized phases.
// Needs mbe_pkg and the block's RTL only; prediction runs in an in-bench fixed-point model.
`timescale 1ns / 1ps

module tb;
   import mbe_pkg::*;

   // Indexes outside the register map: writes there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   localparam int PLAN_LEN      = 41;
   localparam int NUM_PHASES    = 31;
   localparam int PHASE_ITEMS   = 40;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 40;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int PRINT_CAP     = 40;

   // Q12.28 working range and the escape bound 4.0
   localparam longint Q_HI       = (longint'(1) <<< 39) - 1;
   localparam longint Q_LO       = -(longint'(1) <<< 39);
   localparam longint MAG2_LIMIT = longint'(4) <<< FRAC_BITS;
   localparam longint BIG_Z      = longint'(1) <<< 31;

   // Sender idle percentage per phase, cycled: none, heavy, none, light
   localparam int IDLE_PCT [4] = '{0, 73, 0, 20};

   // Register values at the corners of the signed Q4.28 range
   localparam logic [CSR_W-1:0] CORNER_VALUES [5] =
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF};

   typedef enum logic {PLAN_WRITE, PLAN_PIXEL} plan_kind_type;

   typedef struct {
      plan_kind_type          kind;
      logic [CSR_IDX_W-1:0]   idx;
      logic [CSR_W-1:0]       data;
      logic [COORD_W-1:0]     col;
      logic [COORD_W-1:0]     prow;
      bit                     known;
      logic [CNT_W-1:0]       count;
   } plan_row_type;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] prow;
      logic [CNT_W-1:0]   count;
   } pixel_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [COORD_W-1:0]    req_column = '0;
   logic [COORD_W-1:0]    req_pixel_row = '0;
   logic                  rsp_strobe;
   logic [COORD_W-1:0]    rsp_out_column;
   logic [COORD_W-1:0]    rsp_out_row;
   logic [CNT_W-1:0]      rsp_iteration_count;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   // Bench copy of the register file, loaded with the reset values
   logic [CNT_W-1:0]         cfg_limit    = 24'd1000;
   logic signed [CSR_W-1:0]  cfg_left     = 32'shE000_0000;
   logic signed [CSR_W-1:0]  cfg_col_step = 32'sh0004_0000;
   logic signed [CSR_W-1:0]  cfg_lower    = 32'shF000_0000;
   logic signed [CSR_W-1:0]  cfg_row_step = 32'sh0004_0000;

   pixel_result_type  pending_pixels [$];
   pixel_result_type  head;
   plan_row_type      plan [PLAN_LEN];
   int                mismatches = 0;
   int                cycle_count = 0;

   mandelbrot_escape_count u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_column          (req_column),
      .req_pixel_row       (req_pixel_row),
      .rsp_strobe          (rsp_strobe),
      .rsp_out_column      (rsp_out_column),
      .rsp_out_row         (rsp_out_row),
      .rsp_iteration_count (rsp_iteration_count),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Clamp a sum to the signed 40-bit working range
   function automatic longint clamp_q(input longint v);
      if (v > Q_HI)
         return Q_HI;
      if (v < Q_LO)
         return Q_LO;
      return v;
   endfunction

   // Escape-time count for one pixel under the current bench registers.
   // Products are exact in 64 bits (z stays near 2 while iterating); an arithmetic
   // shift by 28 is the floor toward minus infinity.
   function automatic logic [CNT_W-1:0] escape_count(input logic [COORD_W-1:0] col,
                                                      input logic [COORD_W-1:0] prow);
      longint c_re, c_im, x, y, x_next, y_next, ax, ay, mag2;
      logic [CNT_W-1:0] n;
      c_re = clamp_q(longint'(cfg_left) + longint'(col) * longint'(cfg_col_step));
      c_im = clamp_q(longint'(cfg_lower) + longint'(prow) * longint'(cfg_row_step));
      x = 0;
      y = 0;
      mag2 = 0;
      n = '0;
      while (n < cfg_limit && mag2 < MAG2_LIMIT) begin
         x_next = clamp_q(((x * x - y * y) >>> FRAC_BITS) + c_re);
         y_next = clamp_q(((2 * x * y) >>> FRAC_BITS) + c_im);
         x = x_next;
         y = y_next;
         ax = (x < 0) ? -x : x;
         ay = (y < 0) ? -y : y;
         // Past 8.0 on either axis the squared magnitude pins at the top of the range
         if (ax >= BIG_Z || ay >= BIG_Z)
            mag2 = Q_HI;
         else
            mag2 = clamp_q((ax * ax + ay * ay) >>> FRAC_BITS);
         n++;
      end
      return n;
   endfunction

   function automatic plan_row_type wr(input logic [CSR_IDX_W-1:0] idx,
                                       input logic [CSR_W-1:0] data);
      plan_row_type r;
      r = '{PLAN_WRITE, idx, data, '0, '0, 1'b0, '0};
      return r;
   endfunction

   function automatic plan_row_type px(input logic [COORD_W-1:0] col,
                                       input logic [COORD_W-1:0] prow);
      plan_row_type r;
      r = '{PLAN_PIXEL, '0, '0, col, prow, 1'b0, '0};
      return r;
   endfunction

   function automatic plan_row_type px_known(input logic [COORD_W-1:0] col,
                                             input logic [COORD_W-1:0] prow,
                                             input logic [CNT_W-1:0] count);
      plan_row_type r;
      r = '{PLAN_PIXEL, '0, '0, col, prow, 1'b1, count};
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("ERROR %0t ns: %s", $realtime, what);
   endtask

   // Drive one register write; leave csr_we high so back-to-back writes need no drop
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_MAX_ITER: cfg_limit    = data[CNT_W-1:0];
         CSR_LEFT:     cfg_left     = data;
         CSR_COL_STEP: cfg_col_step = data;
         CSR_LOWER:    cfg_lower    = data;
         CSR_ROW_STEP: cfg_row_step = data;
         default: ;
      endcase
   endtask

   // Offer one pixel and hold it until accepted; start stays high on return so the
   // caller decides whether the next item follows at once or the line goes idle
   task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] prow,
                             input bit known, input logic [CNT_W-1:0] count);
      pixel_result_type entry;
      start         <= 1'b1;
      req_column    <= col;
      req_pixel_row <= prow;
      do
         @(posedge clock);
      while (busy);
      entry.col   = col;
      entry.prow  = prow;
      entry.count = known ? count : escape_count(col, prow);
      pending_pixels.push_back(entry);
   endtask

   // Drop start, drain every outstanding item, then pause before touching registers
   task automatic settle();
      start <= 1'b0;
      while (pending_pixels.size() != 0 || busy)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result checker: results cannot be held off, so take every strobe as it comes
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("result col %0d row %0d count %0d with no item pending",
                                      rsp_out_column, rsp_out_row, rsp_iteration_count));
         end else begin
            head = pending_pixels.pop_front();
            if (rsp_out_column !== head.col)
               report_mismatch($sformatf("out_column %0d, want %0d",
                                         rsp_out_column, head.col));
            if (rsp_out_row !== head.prow)
               report_mismatch($sformatf("out_row %0d, want %0d", rsp_out_row, head.prow));
            if (rsp_iteration_count !== head.count)
               report_mismatch($sformatf("pixel (%0d,%0d): iteration_count %0d, want %0d",
                                         head.col, head.prow, rsp_iteration_count,
                                         head.count));
         end
      end
   end

   // Watchdog: a hung handshake or a lost result ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      logic [CSR_W-1:0] lim, left, cstep, lower, rstep;
      int               geo;
      int               idle;

      // Directed plan. Known counts: corners of the reset window escape at once,
      // the origin never escapes and runs to the limit, c = -2 sits exactly on the
      // escape bound, a zero limit gives zero, and saturated or far coordinates
      // escape on the first step even with the largest limit.
      plan = '{
         px_known(12'd0,    12'd0,    24'd1),
         px_known(12'd4095, 12'd4095, 24'd1),
         px_known(12'd2048, 12'd1024, 24'd1000),
         px_known(12'd0,    12'd1024, 24'd1),
         wr(CSR_MAX_ITER, 32'h0000_0000),
         px_known(12'd2048, 12'd1024, 24'd0),
         px_known(12'd4095, 12'd4095, 24'd0),
         wr(CSR_MAX_ITER, 32'hFFFF_FFFF),
         wr(CSR_LEFT,     32'h7FFF_FFFF),
         wr(CSR_COL_STEP, 32'h7FFF_FFFF),
         wr(CSR_LOWER,    32'h8000_0000),
         wr(CSR_ROW_STEP, 32'h8000_0000),
         px_known(12'd0,    12'd0,    24'd1),
         px_known(12'd4095, 12'd4095, 24'd1),
         px_known(12'd4095, 12'd0,    24'd1),
         wr(CSR_LEFT,     32'h8000_0000),
         wr(CSR_COL_STEP, 32'h0000_0000),
         wr(CSR_LOWER,    32'h0000_0000),
         wr(CSR_ROW_STEP, 32'h0000_0000),
         wr(CSR_MAX_ITER, 32'hAB00_0028),
         wr(CSR_UNMAPPED_LO, 32'hFFFF_FFFF),
         wr(CSR_UNMAPPED_HI, 32'h7FFF_FFFF),
         px_known(12'd1234, 12'd3210, 24'd1),
         wr(CSR_LEFT,     32'hF400_0000),
         wr(CSR_COL_STEP, 32'h0000_0001),
         wr(CSR_LOWER,    32'h0199_9999),
         wr(CSR_ROW_STEP, 32'hFFFF_FFFF),
         wr(CSR_MAX_ITER, 32'h0000_0019),
         px(12'd0,    12'd0),
         px(12'd4095, 12'd0),
         px(12'd0,    12'd4095),
         px(12'd2730, 12'd1365),
         wr(CSR_LEFT,     32'hE800_0000),
         wr(CSR_COL_STEP, 32'h0001_0000),
         wr(CSR_LOWER,    32'hFC00_0000),
         wr(CSR_ROW_STEP, 32'h0002_0000),
         wr(CSR_MAX_ITER, 32'h0000_003C),
         px(12'd1365, 12'd2730),
         px(12'd2047, 12'd2048),
         px(12'd4095, 12'd1),
         px(12'd1,    12'd4095)
      };

      // Hold reset at the start, then release it once for the whole run
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Walk the plan; drain before each group of writes, drop csr_we after it
      for (int i = 0; i < PLAN_LEN; i++) begin
         if (plan[i].kind == PLAN_WRITE) begin
            if (i == 0 || plan[i-1].kind != PLAN_WRITE)
               settle();
            csr_write(plan[i].idx, plan[i].data);
         end else begin
            if (i > 0 && plan[i-1].kind == PLAN_WRITE)
               csr_we <= 1'b0;
            send_pixel(plan[i].col, plan[i].prow, plan[i].known, plan[i].count);
         end
      end

      // Random phases: new registers each phase, then a burst of pixels
      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();

         // Keep the limit small so non-escaping pixels stay cheap; every eighth
         // phase runs a few hundred iterations to exercise long counts
         if (p % 8 == 5)
            lim = $urandom_range(200, 300);
         else begin
            case ($urandom_range(0, 15))
               0:       lim = 0;
               1:       lim = 1;
               default: lim = $urandom_range(2, 48);
            endcase
         end
         lim[CSR_W-1:CNT_W] = 8'($urandom_range(0, 255));

         geo = $urandom_range(0, 3);
         if (geo <= 1) begin
            // Window over the set: left in [-2.5, 0.5], lower in [-1, 1], fine steps
            left  = 32'($urandom_range(0, 32'h3000_0000)) - 32'h2800_0000;
            lower = 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
            cstep = $urandom_range(1, 32'h0002_0000);
            rstep = $urandom_range(1, 32'h0002_0000);
            if ($urandom_range(0, 1) == 1)
               cstep = -cstep;
            if ($urandom_range(0, 1) == 1)
               rstep = -rstep;
         end else if (geo == 2) begin
            left  = $urandom;
            lower = $urandom;
            cstep = $urandom;
            rstep = $urandom;
         end else begin
            left  = CORNER_VALUES[$urandom_range(0, 4)];
            lower = CORNER_VALUES[$urandom_range(0, 4)];
            cstep = CORNER_VALUES[$urandom_range(0, 4)];
            rstep = CORNER_VALUES[$urandom_range(0, 4)];
         end

         csr_write(CSR_MAX_ITER, lim);
         csr_write(CSR_LEFT, left);
         csr_write(CSR_COL_STEP, cstep);
         csr_write(CSR_LOWER, lower);
         csr_write(CSR_ROW_STEP, rstep);
         // Write an unmapped index last so any aliasing corrupts the live setting
         csr_write(3'($urandom_range(CSR_UNMAPPED_LO, CSR_UNMAPPED_HI)), $urandom);
         csr_we <= 1'b0;

         idle = IDLE_PCT[p % 4];
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (idle != 0 && $urandom_range(0, 99) < idle) begin
               start <= 1'b0;
               do
                  @(posedge clock);
               while ($urandom_range(0, 99) < idle);
            end
            send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                       1'b0, '0);
         end
      end

      // Drain, then watch a while longer for stray strobes
      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_pixels.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
